// ----- sv/dot_pkg.sv -----
// Shared types and constants for the dirty offset tracker.
`default_nettype none
package dot_pkg;

  localparam int unsigned ENTITIES  = 2048;
  localparam int unsigned ENT_IDX_W = 11;
  localparam int unsigned IN_OFF_W  = 16;
  localparam int unsigned SERIAL_W  = 16;
  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [1:0] {
    ACT_MARK  = 2'd0,
    ACT_ROUND = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_ALREADY_FULL = 3'd0,
    OUT_DUPLICATE    = 3'd1,
    OUT_APPENDED     = 3'd2,
    OUT_REC_OVERFLOW = 3'd3,
    OUT_NEW_RECORD   = 3'd4,
    OUT_POOL_FULL    = 3'd5,
    OUT_OTHER_DONE   = 3'd6
  } outcome_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ENT,
    ST_EXEC
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clr;     // write one zero entity row of the reset sweep
    logic load;    // capture the item and read its entity row
    logic rd_rec;  // read the record row named by the entity row
    logic commit;  // write back and load the result register
  } dot_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;  // last row of the reset sweep
    logic out_busy;  // result register full and not being taken
  } dot_status_t;

endpackage
`default_nettype wire

// ----- sv/dot_ctrl.sv -----
// Controller state machine of the dirty offset tracker.
`default_nettype none
module dot_ctrl
  import dot_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  dot_status_t      status_i,
  output dot_cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ENT;
        end
      end
      ST_ENT: begin
        cmd_o.rd_rec = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/dot_datapath.sv -----
// Datapath of the dirty offset tracker: entity and record memories and the update logic.
`default_nettype none
module dot_datapath
  import dot_pkg::*;
#(
  parameter int unsigned MAX_OFFSETS = 16,
  parameter int unsigned MAX_RECORDS = 128,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  dot_cmd_t                    cmd_i,
  output dot_status_t                 status_o,
  input  wire logic [1:0]             s_axis_tuser,
  input  wire logic [31:0]            s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [15:0]                 m_axis_tdata
);

  localparam int unsigned RIW   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned UW    = $clog2(MAX_RECORDS + 1);
  localparam int unsigned CW    = $clog2(MAX_OFFSETS + 1);
  localparam int unsigned ROW_W = MAX_OFFSETS * OFFSET_BITS;
  localparam int unsigned ENT_W = 2 + RIW + SERIAL_W;

  // Entity row: {serial, record index, full flag, changed flag}.
  logic [ENT_W-1:0] ent_mem [ENTITIES];
  logic [ENT_W-1:0] ent_rdata_q;
  logic [ROW_W-1:0] rec_mem [MAX_RECORDS];
  logic [ROW_W-1:0] rec_rdata_q;
  logic [CW-1:0]    cnt_mem [MAX_RECORDS];
  logic [CW-1:0]    cnt_rdata_q;

  logic [ENT_IDX_W-1:0] clr_cnt_q;
  logic [1:0]           act_q;
  logic [ENT_IDX_W-1:0] ent_q;
  logic [IN_OFF_W-1:0]  off_q;
  logic [SERIAL_W-1:0]  round_q, round_d;
  logic [UW-1:0]        used_q, used_d;
  logic                 m_valid_q;
  logic [15:0]          m_data_q, m_data_d;

  logic                   e_changed, e_full;
  logic [RIW-1:0]         e_ridx;
  logic [SERIAL_W-1:0]    e_ser;
  logic [OFFSET_BITS-1:0] off_m;
  logic                   match, dup;
  logic [CW-1:0]          n;
  logic [SERIAL_W-1:0]    round_next;

  logic                   n_changed, n_full;
  logic [RIW-1:0]         n_ridx;
  logic [SERIAL_W-1:0]    n_ser;
  logic                   rec_we;
  logic [RIW-1:0]         rec_wa;
  logic [ROW_W-1:0]       rec_wd;
  logic [CW-1:0]          cnt_wd;
  logic [CW-1:0]          held;
  outcome_e               outcome;

  assign {e_ser, e_ridx, e_full, e_changed} = ent_rdata_q;
  assign off_m      = OFFSET_BITS'(off_q);
  assign match      = (e_ser == round_q);
  assign n          = (cnt_rdata_q > CW'(MAX_OFFSETS)) ? CW'(MAX_OFFSETS) : cnt_rdata_q;
  assign round_next = (round_q + 1'b1 == '0) ? SERIAL_W'(1) : round_q + 1'b1;

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_OFFSETS; i++) begin
      if ((CW'(i) < n) && (rec_rdata_q[i*OFFSET_BITS +: OFFSET_BITS] == off_m)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    n_changed = e_changed;
    n_full    = e_full;
    n_ridx    = e_ridx;
    n_ser     = e_ser;
    rec_we    = 1'b0;
    rec_wa    = e_ridx;
    rec_wd    = rec_rdata_q;
    cnt_wd    = n + 1'b1;
    round_d   = round_q;
    used_d    = used_q;
    held      = match ? cnt_rdata_q : '0;
    outcome   = OUT_OTHER_DONE;
    for (int i = 0; i < MAX_OFFSETS; i++) begin
      if (CW'(i) == n) begin
        rec_wd[i*OFFSET_BITS +: OFFSET_BITS] = off_m;
      end
    end
    unique case (act_q)
      ACT_MARK: begin
        if (e_full) begin
          outcome = OUT_ALREADY_FULL;
        end else begin
          n_changed = 1'b1;
          if (match) begin
            if (dup) begin
              outcome = OUT_DUPLICATE;
            end else if (n == CW'(MAX_OFFSETS)) begin
              n_ser   = '0;
              n_full  = 1'b1;
              held    = '0;
              outcome = OUT_REC_OVERFLOW;
            end else begin
              rec_we  = 1'b1;
              held    = n + 1'b1;
              outcome = OUT_APPENDED;
            end
          end else if (used_q >= UW'(MAX_RECORDS)) begin
            n_ser   = '0;
            n_full  = 1'b1;
            held    = '0;
            outcome = OUT_POOL_FULL;
          end else begin
            n_ridx  = RIW'(used_q);
            n_ser   = round_q;
            used_d  = used_q + 1'b1;
            rec_we  = 1'b1;
            rec_wa  = RIW'(used_q);
            rec_wd  = ROW_W'(off_m);
            cnt_wd  = CW'(1);
            held    = CW'(1);
            outcome = OUT_NEW_RECORD;
          end
        end
      end
      ACT_ROUND: begin
        round_d = round_next;
        used_d  = '0;
        held    = (e_ser == round_next) ? cnt_rdata_q : '0;
      end
      ACT_CLEAR: begin
        n_changed = 1'b0;
        n_full    = 1'b0;
      end
      default: ;
    endcase
    m_data_d = {6'd0, COUNT_W'(held), n_full, n_changed, outcome};
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      ent_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.commit) begin
      ent_mem[ent_q] <= {n_ser, n_ridx, n_full, n_changed};
    end
    if (cmd_i.load) begin
      ent_rdata_q <= ent_mem[s_axis_tdata[ENT_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
      cnt_mem[rec_wa] <= cnt_wd;
    end
    if (cmd_i.rd_rec) begin
      rec_rdata_q <= rec_mem[e_ridx];
      cnt_rdata_q <= cnt_mem[e_ridx];
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= s_axis_tuser;
      ent_q <= s_axis_tdata[ENT_IDX_W-1:0];
      off_q <= s_axis_tdata[ENT_IDX_W +: IN_OFF_W];
    end
    if (cmd_i.commit) begin
      m_data_q <= m_data_d;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      round_q   <= SERIAL_W'(1);
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.commit) begin
        round_q <= round_d;
        used_q  <= used_d;
      end
      if (cmd_i.commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clr_last = (clr_cnt_q == ENT_IDX_W'(ENTITIES - 1));
  assign status_o.out_busy = m_valid_q && !m_axis_tready;
  assign m_axis_tvalid     = m_valid_q;
  assign m_axis_tdata      = m_data_q;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(MAX_RECORDS))
    else $error("record pool count beyond pool size");
  a_round_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_q != '0)
    else $error("round serial reached zero");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(m_valid_q && !m_axis_tready))
    else $error("result overwritten while still waiting");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clr, cmd_i.load, cmd_i.rd_rec, cmd_i.commit}))
    else $error("more than one datapath command at once");
`endif

endmodule
`default_nettype wire

// ----- sv/dirty_offset_tracker.sv -----
// Top level of the dirty offset tracker: controller plus datapath.
//
//  Channel  | Dir | Handshake                    | Payload
//  ---------+-----+------------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser action; tdata entity, offset
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata outcome, flags, offset count
//
// Each item is handled in order: the entity row is read, then the record row it
// points at, then all held offsets are compared at once and both rows are written back.
// The single-port entity and record memories force these steps to run one after another.
// After reset the block sweeps all 2048 rows of the entity memory clear, one row a
// cycle, and holds s_axis_tready low during the sweep.
// A new item is taken while a result still waits in the output register; the write
// back of the next item waits until that result is taken.
`default_nettype none
module dirty_offset_tracker
  import dot_pkg::*;
#(
  parameter int unsigned MAX_OFFSETS = 16,
  parameter int unsigned MAX_RECORDS = 128,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] action
  input  wire logic [31:0] s_axis_tdata,   // [10:0] entity_index, [26:11] field_offset
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [2:0] outcome, [3] changed_flag,
                                           // [4] full_changed_flag, [9:5] offset_count
);

  dot_cmd_t    cmd;
  dot_status_t status;

  dot_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  dot_datapath #(
    .MAX_OFFSETS (MAX_OFFSETS),
    .MAX_RECORDS (MAX_RECORDS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
